@@ src/ssa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ssa_pkg;

	localparam int IO_WIDTH       = 64;
	localparam int DATA_WIDTH_DEF = 64;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} op_t;

	// classification made by the front end, carried with each queued item
	typedef struct packed {
		op_t  op;
		logic sa;
		logic sb;
		logic bzero;
		logic lt;
		logic eq;
		logic gt;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

endpackage
`default_nettype wire

@@ src/ssa_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssa_front #(
	parameter int DATA_WIDTH = ssa_pkg::DATA_WIDTH_DEF
) (
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [2:0]                          req_type,
	input  logic signed [ssa_pkg::IO_WIDTH-1:0] operand_a,
	input  logic signed [ssa_pkg::IO_WIDTH-1:0] operand_b,
	input  logic                                full,
	output logic                                push,
	output ssa_pkg::ctl_t                       ctl,
	output logic [4*DATA_WIDTH-1:0]             data
);
	import ssa_pkg::*;

	logic signed [DATA_WIDTH-1:0] a_w;
	logic signed [DATA_WIDTH-1:0] b_w;
	logic [DATA_WIDTH-1:0]        ma;
	logic [DATA_WIDTH-1:0]        mb;

	assign a_w = operand_a[DATA_WIDTH-1:0];
	assign b_w = operand_b[DATA_WIDTH-1:0];

	// magnitudes; the minimum maps to 2^(W-1), which still fits unsigned
	assign ma = a_w[DATA_WIDTH-1] ? (~a_w + 1'b1) : a_w;
	assign mb = b_w[DATA_WIDTH-1] ? (~b_w + 1'b1) : b_w;

	assign req_ready = !full;
	assign push      = req_valid && !full;

	always_comb begin
		ctl.op    = op_t'(req_type);
		ctl.sa    = a_w[DATA_WIDTH-1];
		ctl.sb    = b_w[DATA_WIDTH-1];
		ctl.bzero = (b_w == '0);
		ctl.lt    = (a_w < b_w);
		ctl.eq    = (a_w == b_w);
		ctl.gt    = (a_w > b_w);
	end

	assign data = {a_w, b_w, ma, mb};

endmodule
`default_nettype wire

@@ src/ssa_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/ssa_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ssa_back #(
	parameter int DATA_WIDTH = ssa_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	input  ssa_pkg::ctl_t                       ctl,
	input  logic [4*DATA_WIDTH-1:0]             data,
	output logic                                pop,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [ssa_pkg::IO_WIDTH-1:0] result_value,
	output logic                                saturated,
	output logic                                div_zero,
	output logic                                a_less,
	output logic                                a_equal,
	output logic                                a_greater
);
	import ssa_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int H  = (DATA_WIDTH + 1) / 2;
	localparam int W2 = 2 * DATA_WIDTH;
	localparam int CW = $clog2(DATA_WIDTH + 1);

	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t        state_q;
	ctl_t          ctl_q;
	logic [W-1:0]  ma_q;
	logic [W-1:0]  mb_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W2-1:0] acc_q;
	logic [2*H-1:0] prod_q;
	logic [2:0]    step_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0]  res_q;
	logic          res_valid_q;
	logic          sat_q;
	logic          dz_q;
	logic          lt_q;
	logic          eq_q;
	logic          gt_q;

	logic [W-1:0]  a_in;
	logic [W-1:0]  b_in;
	logic [W-1:0]  ma_in;
	logic [W-1:0]  mb_in;
	logic          out_free;

	assign {a_in, b_in, ma_in, mb_in} = data;
	assign out_free = !res_valid_q || res_ready;

	// add/sub, zero divisor and unknown codes finish straight from the queue head
	logic [W:0]    sum;
	logic [W-1:0]  dir_res;
	logic          dir_sat;
	logic          dir_dz;
	logic          is_long;

	always_comb begin
		sum     = '0;
		dir_res = '0;
		dir_sat = 1'b0;
		dir_dz  = 1'b0;
		is_long = 1'b0;
		case (ctl.op)
			OP_ADD, OP_SUB: begin
				if (ctl.op == OP_ADD) begin
					sum = {a_in[W-1], a_in} + {b_in[W-1], b_in};
				end else begin
					sum = {a_in[W-1], a_in} - {b_in[W-1], b_in};
				end
				if (sum[W] != sum[W-1]) begin
					dir_sat = 1'b1;
					dir_res = ctl.sa ? SMIN : SMAX;
				end else begin
					dir_res = sum[W-1:0];
				end
			end
			OP_MUL: begin
				is_long = 1'b1;
			end
			OP_DIV, OP_REM: begin
				if (ctl.bzero) begin
					dir_dz = 1'b1;
				end else begin
					is_long = 1'b1;
				end
			end
			default: begin
				dir_res = '0;
			end
		endcase
	end

	// multiply: four half-width partial products, one per cycle
	logic [H-1:0]  a0, a1, b0, b1;
	logic [H-1:0]  mul_x, mul_y;
	logic [W2-1:0] pext;
	logic [W2-1:0] padd;

	assign a0 = ma_q[H-1:0];
	assign a1 = H'(ma_q[W-1:H]);
	assign b0 = mb_q[H-1:0];
	assign b1 = H'(mb_q[W-1:H]);
	assign pext = W2'(prod_q);

	always_comb begin
		case (step_q)
			3'd0: begin mul_x = a0; mul_y = b0; end
			3'd1: begin mul_x = a0; mul_y = b1; end
			3'd2: begin mul_x = a1; mul_y = b0; end
			default: begin mul_x = a1; mul_y = b1; end
		endcase
		case (step_q)
			3'd1: padd = pext;
			3'd2, 3'd3: padd = pext << H;
			default: padd = pext << (2 * H);
		endcase
	end

	// restoring divide, one quotient bit per cycle
	logic [W:0]   dshift;
	logic [W:0]   dtrial;

	assign dshift = {rem_q, quo_q[W-1]};
	assign dtrial = dshift - {1'b0, mb_q};

	// final saturation for long operations
	logic [W-1:0] fin_res;
	logic         fin_sat;
	logic         neg_q;
	logic [W-1:0] mlo;

	assign neg_q = ctl_q.sa ^ ctl_q.sb;
	assign mlo   = acc_q[W-1:0];

	always_comb begin
		fin_res = '0;
		fin_sat = 1'b0;
		case (ctl_q.op)
			OP_MUL: begin
				if ((acc_q[W2-1:W] != '0) || (mlo > (neg_q ? SMIN : SMAX))) begin
					fin_sat = 1'b1;
					fin_res = neg_q ? SMIN : SMAX;
				end else begin
					fin_res = neg_q ? (~mlo + 1'b1) : mlo;
				end
			end
			OP_DIV: begin
				if (!neg_q && quo_q[W-1]) begin
					fin_sat = 1'b1;
					fin_res = SMAX;
				end else begin
					fin_res = neg_q ? (~quo_q + 1'b1) : quo_q;
				end
			end
			default: begin
				fin_res = ctl_q.sa ? (~rem_q + 1'b1) : rem_q;
			end
		endcase
	end

	assign pop = (state_q == ST_IDLE) && !empty && (is_long || out_free);

	always_ff @(posedge clk) begin
		if (pop && is_long) begin
			ctl_q  <= ctl;
			ma_q   <= ma_in;
			mb_q   <= mb_in;
			acc_q  <= '0;
			rem_q  <= '0;
			quo_q  <= ma_in;
			step_q <= '0;
			cnt_q  <= CW'(W);
		end else begin
			case (state_q)
				ST_MUL: begin
					prod_q <= mul_x * mul_y;
					if (step_q != 3'd0) begin
						acc_q <= acc_q + padd;
					end
					step_q <= step_q + 1'b1;
				end
				ST_DIV: begin
					rem_q  <= dtrial[W] ? dshift[W-1:0] : dtrial[W-1:0];
					quo_q  <= {quo_q[W-2:0], ~dtrial[W]};
					cnt_q  <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (is_long) begin
							state_q <= (ctl.op == OP_MUL) ? ST_MUL : ST_DIV;
						end else begin
							res_valid_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					if (step_q == 3'd4) begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (cnt_q == CW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !is_long) begin
			res_q <= dir_res;
			sat_q <= dir_sat;
			dz_q  <= dir_dz;
			lt_q  <= ctl.lt;
			eq_q  <= ctl.eq;
			gt_q  <= ctl.gt;
		end else if ((state_q == ST_FIN) && out_free) begin
			res_q <= fin_res;
			sat_q <= fin_sat;
			dz_q  <= 1'b0;
			lt_q  <= ctl_q.lt;
			eq_q  <= ctl_q.eq;
			gt_q  <= ctl_q.gt;
		end
	end

	assign res_valid    = res_valid_q;
	assign result_value = IO_WIDTH'(signed'(res_q));
	assign saturated    = sat_q;
	assign div_zero     = dz_q;
	assign a_less       = lt_q;
	assign a_equal      = eq_q;
	assign a_greater    = gt_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && dz_q |-> (res_q == '0) && !sat_q)
		else $error("div_zero with nonzero result or saturation");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $onehot({lt_q, eq_q, gt_q}))
		else $error("compare flags not exclusive");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty && (state_q == ST_IDLE))
		else $error("pop from empty queue or while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && !out_free |=> (state_q == ST_FIN) && res_valid_q)
		else $error("finished item lost while output stalled");
`endif

endmodule
`default_nettype wire

@@ src/saturating_signed_alu_top.sv @@
// Saturating signed ALU.
// Request channel: req_valid/req_ready with req_type (0 add, 1 sub, 2 mul,
// 3 div, 4 rem) and two signed operands; only the low DATA_WIDTH bits count.
// Result channel: res_valid/res_ready with result_value (sign-extended to 64
// bits), saturated, div_zero and the signed compare flags a_less, a_equal,
// a_greater. Exactly one result per request, in request order.
// A front end classifies each request and writes it into a two-entry queue;
// the back end executes from the queue head into an output register.
// Add, subtract, zero-divisor and unknown codes: one item per cycle
// sustained while res_ready is high. Multiply: four half-width partial
// products through one multiplier. Divide and remainder: restoring divider,
// one quotient bit per cycle. The back end holds one multiply or divide at
// a time; the queue keeps accepting behind it.
// When res_ready is low the result register holds and the back end waits;
// requests keep entering until the queue is full.
// Reset (arst_n low) empties the queue and drops any result in flight.
`timescale 1ns / 1ps
`default_nettype none
module saturating_signed_alu_top #(
	parameter int DATA_WIDTH = ssa_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [2:0]                          req_type,
	input  logic signed [ssa_pkg::IO_WIDTH-1:0] operand_a,
	input  logic signed [ssa_pkg::IO_WIDTH-1:0] operand_b,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [ssa_pkg::IO_WIDTH-1:0] result_value,
	output logic                                saturated,
	output logic                                div_zero,
	output logic                                a_less,
	output logic                                a_equal,
	output logic                                a_greater
);
	import ssa_pkg::*;

	localparam int QW = CTL_W + 4 * DATA_WIDTH;

	logic                    full;
	logic                    empty;
	logic                    push;
	logic                    pop;
	ctl_t                    f_ctl;
	ctl_t                    b_ctl;
	logic [4*DATA_WIDTH-1:0] f_data;
	logic [4*DATA_WIDTH-1:0] b_data;
	logic [QW-1:0]           q_rdata;

	ssa_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.full      (full),
		.push      (push),
		.ctl       (f_ctl),
		.data      (f_data)
	);

	ssa_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_ctl, f_data}),
		.full   (full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (empty)
	);

	assign {b_ctl, b_data} = q_rdata;

	ssa_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.ctl          (b_ctl),
		.data         (b_data),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.result_value (result_value),
		.saturated    (saturated),
		.div_zero     (div_zero),
		.a_less       (a_less),
		.a_equal      (a_equal),
		.a_greater    (a_greater)
	);

endmodule
`default_nettype wire
